### sv/trvg_pkg.sv
// trvg_pkg: shared types, constants and the arctangent table of the
// tube ring vertex generator. Depends on nothing.
package trvg_pkg;

  // angles in Q3.29 radians
  localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
  localparam logic [31:0] PI_Q29         = 32'd1686629713;
  localparam logic [31:0] HALF_PI_Q29    = 32'd843314857;
  localparam logic [31:0] QUARTER_PI_Q29 = 32'd421657428;
  localparam logic [31:0] CORDIC_GAIN    = 32'd652032874;

  // default values of the top level parameters
  localparam int DEF_MAX_SLICES   = 63;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_TEX_V_SCALE  = 40;

  // largest cordic length the table serves
  localparam int MAX_CORDIC = 24;

  // shared divider geometry
  localparam int DIV_QW = 24;
  localparam int DIV_DW = 32;
  localparam int DIV_NW = DIV_QW + DIV_DW - 8;

  // register indexes
  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_SLICES       = 2'd1;
  localparam logic [1:0] REG_ANGLE_STEP   = 2'd2;
  localparam logic [1:0] REG_CIRCLE_TOTAL = 2'd3;

  // register reset values
  localparam logic [30:0] RST_RADIUS       = 31'd65536;
  localparam logic [5:0]  RST_SLICES       = 6'd16;
  localparam logic [31:0] RST_ANGLE_STEP   = 32'd210828714;
  localparam logic [15:0] RST_CIRCLE_TOTAL = 16'd1;

  typedef logic [31:0] atan_tab_t [MAX_CORDIC];

  // atan(2^-k) as an alternating series in Q2.62, rounded to Q29
  function automatic logic [31:0] atan_q29(input int k);
    longint sum;
    longint term;
    int     e;
    sum = 0;
    if (k == 0) begin
      return QUARTER_PI_Q29;
    end
    for (int n = 0; n < 32; n++) begin
      e = k * (2 * n + 1);
      if (e <= 62) begin
        term = longint'((64'd1 << (62 - e)) / 64'(2 * n + 1));
        sum  = (n % 2 == 1) ? sum - term : sum + term;
      end
    end
    return 32'((sum + (64'sd1 <<< 32)) >>> 33);
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t t;
    for (int k = 0; k < MAX_CORDIC; k++) begin
      t[k] = atan_q29(k);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_TEXV_WAIT, S_FOLD, S_CORDIC, S_RC, S_RS, S_OFF, S_SHIFT, S_SQ,
    S_SQRT_INIT, S_SQRT, S_NDIV, S_NWAIT, S_UDIV, S_UWAIT, S_EMIT
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_RING, OP_TEXV_SAVE, OP_FOLD, OP_CORDIC, OP_RC, OP_RS, OP_OFF,
    OP_SHIFT, OP_SQ, OP_SQRT_INIT, OP_SQRT, OP_NDIV, OP_NSAVE, OP_UDIV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last;
    logic emit_ok;
  } stat_t;

endpackage

### sv/trvg_div.sv
// trvg_div: restoring divider, one quotient bit per cycle.
// Depends on trvg_pkg; the dividend must stay below divisor * 2^DIV_QW.
module trvg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [trvg_pkg::DIV_NW-1:0] num,
  input  logic [trvg_pkg::DIV_DW-1:0] den,
  output logic                       busy,
  output logic [trvg_pkg::DIV_QW-1:0] quo
);
  import trvg_pkg::*;

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_QW-1:0] low_r, q_r;
  logic [DIV_DW-1:0] den_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign trial   = {rem_r, low_r[DIV_QW-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(DIV_QW);
      rem_r  <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
      low_r  <= num[DIV_QW-1:0];
      den_r  <= den;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_r[DIV_QW-2:0], 1'b0};
      q_r    <= {q_r[DIV_QW-2:0], ge};
      cnt_r  <= cnt_r - 5'd1;
      busy_r <= (cnt_r != 5'd1);
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

### sv/trvg_ctrl.sv
// trvg_ctrl: sequencer that walks each ring vertex by vertex through the
// datapath operations. Depends on trvg_pkg.
module trvg_ctrl #(
  parameter int CORDIC_STEPS = trvg_pkg::DEF_CORDIC_STEPS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output trvg_pkg::cmd_t cmd,
  input  trvg_pkg::stat_t stat
);
  import trvg_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_RING;
          state_nxt = S_TEXV_WAIT;
        end
      end
      S_TEXV_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_TEXV_SAVE;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        cnt_nxt   = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_RC;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_RC: begin
        cmd.op    = OP_RC;
        state_nxt = S_RS;
      end
      S_RS: begin
        cmd.op    = OP_RS;
        cnt_nxt   = '0;
        state_nxt = S_OFF;
      end
      S_OFF: begin
        cmd.op = OP_OFF;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = S_SHIFT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_SHIFT: begin
        cmd.op    = OP_SHIFT;
        cnt_nxt   = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT_INIT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == 6'd31) begin
          cnt_nxt   = '0;
          state_nxt = S_NDIV;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_NDIV: begin
        cmd.op    = OP_NDIV;
        state_nxt = S_NWAIT;
      end
      S_NWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = OP_NSAVE;
          if (cnt_r == 6'd2) begin
            cnt_nxt   = '0;
            state_nxt = S_UDIV;
          end else begin
            cnt_nxt   = cnt_r + 6'd1;
            state_nxt = S_NDIV;
          end
        end
      end
      S_UDIV: begin
        cmd.op    = OP_UDIV;
        state_nxt = S_UWAIT;
      end
      S_UWAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_EMIT;
          state_nxt = stat.last ? S_IDLE : S_FOLD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

### sv/trvg_dp.sv
// trvg_dp: registers, cordic, scaling, normal and texture arithmetic and the
// output beat register. Depends on trvg_pkg and trvg_div.
module trvg_dp #(
  parameter int MAX_SLICES   = trvg_pkg::DEF_MAX_SLICES,
  parameter int TEX_V_SCALE  = trvg_pkg::DEF_TEX_V_SCALE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  trvg_pkg::cmd_t     cmd,
  output trvg_pkg::stat_t    stat,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic signed [15:0] in_first_axis_x,
  input  logic signed [15:0] in_first_axis_y,
  input  logic signed [15:0] in_first_axis_z,
  input  logic signed [15:0] in_second_axis_x,
  input  logic signed [15:0] in_second_axis_y,
  input  logic signed [15:0] in_second_axis_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [21:0]        out_tex_v,
  output logic               out_ring_last
);
  import trvg_pkg::*;

  // configuration and ring state
  logic [30:0] radius_r;
  logic [5:0]  slices_r;
  logic [31:0] step_r;
  logic [15:0] total_r;
  logic [15:0] ring_r;

  // per ring
  logic signed [31:0] cen_r [3];
  logic signed [15:0] ax1_r [3];
  logic signed [15:0] ax2_r [3];
  logic [5:0]  sc_r;
  logic [15:0] tot_r;
  logic [31:0] stepm_r;
  logic [31:0] acc_r;
  logic [5:0]  i_r;
  logic [21:0] texv_r;

  // per vertex
  logic signed [33:0] x_r, y_r, z_r;
  logic               neg_r;
  logic signed [34:0] rc_r, rs_r;
  logic signed [36:0] off_r [3];
  logic [29:0]        ms_r [3];
  logic [61:0]        sq_r;
  logic [62:0]        n_r, res_r, bit_r;
  logic signed [15:0] nrm_r [3];
  logic               out_valid_r;

  logic [1:0] j;
  logic [4:0] k;
  assign j = cmd.idx[1:0];
  assign k = cmd.idx[4:0];

  // clamped slice count and ring total seen at ring start
  logic [5:0]  sc0;
  logic [15:0] tot0;
  always_comb begin
    sc0 = (slices_r == 6'd0) ? 6'd1 : slices_r;
    if (sc0 > 6'(MAX_SLICES)) begin
      sc0 = 6'(MAX_SLICES);
    end
    tot0 = (total_r == 16'd0) ? 16'd1 : total_r;
  end

  // tex v dividend
  logic [15:0]       vdiff;
  logic [DIV_NW-1:0] vnum;
  assign vdiff = (ring_r < tot0) ? 16'(tot0 - ring_r) : 16'd0;
  assign vnum  = ((DIV_NW'(vdiff) * DIV_NW'(TEX_V_SCALE)) << 16) + DIV_NW'(tot0 >> 1);

  // angle fold into [-pi/2, pi/2]
  logic signed [33:0] zf0, zf;
  logic               negf;
  always_comb begin
    zf0  = (acc_r > PI_Q29) ? $signed({2'b00, acc_r}) - $signed({2'b00, TWO_PI_Q29})
                            : $signed({2'b00, acc_r});
    zf   = zf0;
    negf = 1'b0;
    if (zf0 > $signed({2'b00, HALF_PI_Q29})) begin
      zf   = zf0 - $signed({2'b00, PI_Q29});
      negf = 1'b1;
    end else if (zf0 < -$signed({2'b00, HALF_PI_Q29})) begin
      zf   = zf0 + $signed({2'b00, PI_Q29});
      negf = 1'b1;
    end
  end

  // one cordic rotation
  logic signed [33:0] dx, dy, at;
  assign dx = y_r >>> k;
  assign dy = x_r >>> k;
  assign at = $signed({2'b00, ATAN_TAB[k]});

  // radius scaling, shared multiplier for cos and sin
  logic signed [33:0] csel;
  logic signed [65:0] rmul, rrnd;
  assign csel = (cmd.op == OP_RS) ? (neg_r ? -y_r : y_r) : (neg_r ? -x_r : x_r);
  assign rmul = $signed({1'b0, radius_r}) * csel;
  assign rrnd = (rmul + 66'sd536870912) >>> 30;

  // offset of one axis
  logic signed [51:0] osum, ornd;
  assign osum = rc_r * ax1_r[j] + rs_r * ax2_r[j];
  assign ornd = (osum + 52'sd16384) >>> 15;

  // magnitudes and the shift that brings them under 2^30
  logic [36:0] m [3];
  logic [36:0] mx;
  logic [2:0]  sh;
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      m[t] = off_r[t][36] ? 37'(-off_r[t]) : 37'(off_r[t]);
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    sh = 3'd0;
    for (int t = 1; t < 8; t++) begin
      if ((mx >> (29 + t)) != 37'd0) sh = 3'(t);
    end
  end

  // sum of squares
  logic [59:0] sqp;
  assign sqp = ms_r[j] * ms_r[j];

  // square root step
  logic [62:0] rb;
  assign rb = res_r + bit_r;

  // shared divider
  logic              div_start, div_busy;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QW-1:0] quo;
  always_comb begin
    div_start = 1'b0;
    div_num   = vnum;
    div_den   = DIV_DW'(tot0);
    case (cmd.op)
      OP_RING: begin
        div_start = 1'b1;
      end
      OP_NDIV: begin
        div_start = 1'b1;
        div_num   = (DIV_NW'(ms_r[j]) << 15) + DIV_NW'(res_r[31:1]);
        div_den   = res_r[31:0];
      end
      OP_UDIV: begin
        div_start = 1'b1;
        div_num   = (DIV_NW'(i_r) << 16) + DIV_NW'(sc_r >> 1);
        div_den   = DIV_DW'(sc_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  trvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // normal component from the quotient
  logic [15:0] qmag;
  logic signed [15:0] nq;
  always_comb begin
    if (off_r[j][36]) begin
      qmag = (quo > DIV_QW'(32768)) ? 16'd32768 : quo[15:0];
      nq   = -$signed(qmag);
    end else begin
      qmag = (quo > DIV_QW'(32767)) ? 16'd32767 : quo[15:0];
      nq   = $signed(qmag);
    end
    if (res_r[31:0] == 32'd0) begin
      nq = '0;
    end
  end

  // saturated positions
  logic signed [31:0] pos [3];
  logic signed [37:0] psum [3];
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      psum[t] = 38'(cen_r[t]) + 38'(off_r[t]);
      if (psum[t] > 38'sd2147483647) pos[t] = 32'sh7fffffff;
      else if (psum[t] < -38'sd2147483648) pos[t] = 32'sh80000000;
      else pos[t] = psum[t][31:0];
    end
  end

  // next angle, kept reduced modulo two pi
  logic [32:0] acc_sum;
  assign acc_sum = {1'b0, acc_r} + {1'b0, stepm_r};

  logic last;
  assign last = (i_r == sc_r);

  logic [15:0] ring_inc;
  assign ring_inc = (ring_r >= tot_r) ? 16'd0 : ring_r + 16'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_RADIUS;
      slices_r <= RST_SLICES;
      step_r   <= RST_ANGLE_STEP;
      total_r  <= RST_CIRCLE_TOTAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS:       radius_r <= cfg_data[30:0];
        REG_SLICES:       slices_r <= cfg_data[5:0];
        REG_ANGLE_STEP:   step_r   <= cfg_data;
        REG_CIRCLE_TOTAL: total_r  <= cfg_data[15:0];
        default:          radius_r <= radius_r;
      endcase
    end
  end

  // ring counter and output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
        if (last) begin
          ring_r <= (ring_inc >= tot_r) ? 16'd0 : ring_inc;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RING: begin
        cen_r[0] <= in_centre_x;
        cen_r[1] <= in_centre_y;
        cen_r[2] <= in_centre_z;
        ax1_r[0] <= in_first_axis_x;
        ax1_r[1] <= in_first_axis_y;
        ax1_r[2] <= in_first_axis_z;
        ax2_r[0] <= in_second_axis_x;
        ax2_r[1] <= in_second_axis_y;
        ax2_r[2] <= in_second_axis_z;
        sc_r     <= sc0;
        tot_r    <= tot0;
        stepm_r  <= (step_r >= TWO_PI_Q29) ? step_r - TWO_PI_Q29 : step_r;
        acc_r    <= '0;
        i_r      <= '0;
      end
      OP_TEXV_SAVE: begin
        texv_r <= quo[21:0];
      end
      OP_FOLD: begin
        x_r   <= $signed({2'b00, CORDIC_GAIN});
        y_r   <= '0;
        z_r   <= zf;
        neg_r <= negf;
      end
      OP_CORDIC: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
      end
      OP_RC: begin
        rc_r <= rrnd[34:0];
      end
      OP_RS: begin
        rs_r <= rrnd[34:0];
      end
      OP_OFF: begin
        off_r[j] <= ornd[36:0];
      end
      OP_SHIFT: begin
        for (int t = 0; t < 3; t++) begin
          ms_r[t] <= 30'(m[t] >> sh);
        end
        sq_r <= '0;
      end
      OP_SQ: begin
        sq_r <= sq_r + 62'(sqp);
      end
      OP_SQRT_INIT: begin
        n_r   <= 63'(sq_r);
        res_r <= '0;
        bit_r <= 63'd1 << 62;
      end
      OP_SQRT: begin
        if (n_r >= rb) begin
          n_r   <= n_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_NSAVE: begin
        nrm_r[j] <= nq;
      end
      OP_EMIT: begin
        out_pos_x     <= pos[0];
        out_pos_y     <= pos[1];
        out_pos_z     <= pos[2];
        out_norm_x    <= nrm_r[0];
        out_norm_y    <= nrm_r[1];
        out_norm_z    <= nrm_r[2];
        out_tex_u     <= quo[16:0];
        out_tex_v     <= texv_r;
        out_ring_last <= last;
        i_r           <= i_r + 6'd1;
        acc_r         <= (acc_sum >= {1'b0, TWO_PI_Q29}) ? 32'(acc_sum - {1'b0, TWO_PI_Q29})
                                                         : acc_sum[31:0];
      end
      default: begin
        i_r <= i_r;
      end
    endcase
  end

  assign stat.div_busy = div_busy;
  assign stat.last     = last;
  assign stat.emit_ok  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
endmodule

### sv/tube_ring_vertex_generator_unit.sv
// Tube ring vertex generator: one input beat is a ring (centre and two axes),
// and it produces one output beat per slice plus a closing one, each vertex
// with position, unit normal, texture u/v and a last-of-ring flag. Rings are taken
// one at a time. A ring starts with a setup divide for texture v, then each
// vertex runs the CORDIC rotation, the bit-serial square root and four passes
// through the shared radix-2 divider (three normal components and texture u).
// The output register lets the next vertex be computed while a finished one is
// still stalled. Configuration is written through cfg_*, which is always ready
// and should only be written while no ring is in flight.
// Depends on trvg_pkg, trvg_ctrl, trvg_dp and trvg_div.
module tube_ring_vertex_generator_unit #(
  parameter int MAX_SLICES   = trvg_pkg::DEF_MAX_SLICES,
  parameter int CORDIC_STEPS = trvg_pkg::DEF_CORDIC_STEPS,
  parameter int TEX_V_SCALE  = trvg_pkg::DEF_TEX_V_SCALE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic signed [15:0] in_first_axis_x,
  input  logic signed [15:0] in_first_axis_y,
  input  logic signed [15:0] in_first_axis_z,
  input  logic signed [15:0] in_second_axis_x,
  input  logic signed [15:0] in_second_axis_y,
  input  logic signed [15:0] in_second_axis_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [21:0]        out_tex_v,
  output logic               out_ring_last
);
  import trvg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  trvg_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic and output beat register
  trvg_dp #(
    .MAX_SLICES  (MAX_SLICES),
    .TEX_V_SCALE (TEX_V_SCALE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_centre_x      (in_centre_x),
    .in_centre_y      (in_centre_y),
    .in_centre_z      (in_centre_z),
    .in_first_axis_x  (in_first_axis_x),
    .in_first_axis_y  (in_first_axis_y),
    .in_first_axis_z  (in_first_axis_z),
    .in_second_axis_x (in_second_axis_x),
    .in_second_axis_y (in_second_axis_y),
    .in_second_axis_z (in_second_axis_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_norm_x       (out_norm_x),
    .out_norm_y       (out_norm_y),
    .out_norm_z       (out_norm_z),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_ring_last    (out_ring_last)
  );
endmodule

### sim/testbench.sv
// testbench: self-checking bench for tube_ring_vertex_generator_unit with its
// own fixed-point vertex predictor, random stalls on both sides and config phases.
// Depends on trvg_pkg and the rtl of the unit.
module testbench;
  import trvg_pkg::*;

  localparam int  LIMIT_CYCLES = 20000000;
  localparam int  MAX_SHOWN    = 10;
  localparam int  TAIL_CYCLES  = 400;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] bx, by, bz;
  } ring_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [16:0] u;
    logic [21:0] v;
    logic        last;
  } vertex_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_centre_x, in_centre_y, in_centre_z;
  logic signed [15:0] in_first_axis_x, in_first_axis_y, in_first_axis_z;
  logic signed [15:0] in_second_axis_x, in_second_axis_y, in_second_axis_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [16:0]        out_tex_u;
  logic [21:0]        out_tex_v;
  logic               out_ring_last;

  // predictor copy of the registers and ring counter
  logic [30:0] m_radius;
  logic [5:0]  m_slices;
  logic [31:0] m_step;
  logic [15:0] m_total;
  logic [15:0] m_ring;

  vertex_t vertex_q[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_req;
  int      hold_seen = 0;
  int      hold_left = 0;

  tube_ring_vertex_generator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_centre_x(in_centre_x), .in_centre_y(in_centre_y), .in_centre_z(in_centre_z),
    .in_first_axis_x(in_first_axis_x), .in_first_axis_y(in_first_axis_y),
    .in_first_axis_z(in_first_axis_z),
    .in_second_axis_x(in_second_axis_x), .in_second_axis_y(in_second_axis_y),
    .in_second_axis_z(in_second_axis_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v), .out_ring_last(out_ring_last)
  );

  // clock
  always #2 clk = ~clk;

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver stall, with a long counted hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // arctangent of 2^-k in Q29 from the series in Q2.62
  function automatic longint atan_of_shift(int k);
    longint sum;
    longint term;
    int     e;
    sum = 0;
    if (k == 0) return longint'(QUARTER_PI_Q29);
    for (int n = 0; n < 64; n++) begin
      e = k * (2 * n + 1);
      if (e > 62) break;
      term = longint'((64'd1 << (62 - e)) / 64'(2 * n + 1));
      sum = (n % 2 == 1) ? sum - term : sum + term;
    end
    return (sum + (64'sd1 <<< 32)) >>> 33;
  endfunction

  task automatic rotate(input logic [63:0] angle, output longint c, output longint s);
    longint z, x, y, dx, dy, a;
    bit     flip;
    z = longint'(angle % 64'(TWO_PI_Q29));
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 0;
    if (z > longint'(PI_Q29)) z = z - longint'(TWO_PI_Q29);
    if (z > longint'(HALF_PI_Q29)) begin
      z = z - longint'(PI_Q29);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q29)) begin
      z = z + longint'(PI_Q29);
      flip = 1;
    end
    for (int k = 0; k < DEF_CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      a = atan_of_shift(k);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - a;
      end else begin
        x = x + dx; y = y - dy; z = z + a;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // expected vertices of one accepted ring, then the ring counter update
  task automatic predict_ring_vertices(input ring_t r);
    longint      cen[3], fa[3], sa[3], off[3];
    longint      c, s, rc, rs, p;
    logic [63:0] mag[3], mx, sq, len, q;
    int          sc, tot, ring, sh;
    longint      tv;
    vertex_t     vx;
    cen[0] = r.cx; cen[1] = r.cy; cen[2] = r.cz;
    fa[0] = r.ax; fa[1] = r.ay; fa[2] = r.az;
    sa[0] = r.bx; sa[1] = r.by; sa[2] = r.bz;
    sc = (m_slices == 0) ? 1 : m_slices;
    if (sc > DEF_MAX_SLICES) sc = DEF_MAX_SLICES;
    tot = (m_total == 0) ? 1 : m_total;
    ring = m_ring;
    if (ring >= tot) tv = 0;
    else tv = (longint'(tot - ring) * DEF_TEX_V_SCALE * 65536 + tot / 2) / tot;
    for (int i = 0; i <= sc; i++) begin
      rotate(64'(i) * 64'(m_step), c, s);
      rc = (longint'(m_radius) * c + (64'sd1 <<< 29)) >>> 30;
      rs = (longint'(m_radius) * s + (64'sd1 <<< 29)) >>> 30;
      mx = 0;
      for (int j = 0; j < 3; j++) begin
        off[j] = (rc * fa[j] + rs * sa[j] + (64'sd1 <<< 14)) >>> 15;
        p = cen[j] + off[j];
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        if (j == 0) vx.px = p[31:0];
        else if (j == 1) vx.py = p[31:0];
        else vx.pz = p[31:0];
        mag[j] = (off[j] < 0) ? 64'(-off[j]) : 64'(off[j]);
        if (mag[j] > mx) mx = mag[j];
      end
      // unit normal of the offset, zero when the offset is zero
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      sq = 0;
      for (int j = 0; j < 3; j++) begin
        mag[j] = mag[j] >> sh;
        sq = sq + mag[j] * mag[j];
      end
      len = floor_sqrt(sq);
      for (int j = 0; j < 3; j++) begin
        if (len == 0) begin
          p = 0;
        end else begin
          q = (mag[j] * 32768 + len / 2) / len;
          if (off[j] < 0) p = -longint'((q > 32768) ? 64'd32768 : q);
          else p = longint'((q > 32767) ? 64'd32767 : q);
        end
        if (j == 0) vx.nx = p[15:0];
        else if (j == 1) vx.ny = p[15:0];
        else vx.nz = p[15:0];
      end
      vx.u = 17'((longint'(i) * 65536 + sc / 2) / sc);
      vx.v = tv[21:0];
      vx.last = (i == sc);
      vertex_q = {vertex_q, vx};
    end
    ring = (ring >= tot) ? 0 : ring + 1;
    if (ring >= tot) ring = 0;
    m_ring = ring[15:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < MAX_SHOWN)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        if (mismatches < MAX_SHOWN) $display("mismatch: vertex beat with none expected");
        mismatches++;
      end else begin
        e = vertex_q.pop_front();
        check_field("pos_x", e.px, out_pos_x);
        check_field("pos_y", e.py, out_pos_y);
        check_field("pos_z", e.pz, out_pos_z);
        check_field("norm_x", 32'(e.nx), 32'(out_norm_x[15:0]));
        check_field("norm_y", 32'(e.ny), 32'(out_norm_y[15:0]));
        check_field("norm_z", 32'(e.nz), 32'(out_norm_z[15:0]));
        check_field("tex_u", 32'(e.u), 32'(out_tex_u));
        check_field("tex_v", 32'(e.v), 32'(out_tex_v));
        check_field("ring_last", 32'(e.last), 32'(out_ring_last));
      end
    end
  end

  // one ring beat, with an optional random gap after it
  task automatic send_ring(input ring_t r);
    in_valid         <= 1'b1;
    in_centre_x      <= r.cx;
    in_centre_y      <= r.cy;
    in_centre_z      <= r.cz;
    in_first_axis_x  <= r.ax;
    in_first_axis_y  <= r.ay;
    in_first_axis_z  <= r.az;
    in_second_axis_x <= r.bx;
    in_second_axis_y <= r.by;
    in_second_axis_z <= r.bz;
    do @(posedge clk); while (in_stall);
    predict_ring_vertices(r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic ring_t random_ring();
    ring_t r;
    r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
    // keep most centres away from the rails so offsets show
    if ($urandom_range(0, 3) != 0) begin
      r.cx = r.cx >>> 4; r.cy = r.cy >>> 4; r.cz = r.cz >>> 4;
    end
    r.ax = $urandom_range(0, 65535); r.ay = $urandom_range(0, 65535);
    r.az = $urandom_range(0, 65535);
    r.bx = $urandom_range(0, 65535); r.by = $urandom_range(0, 65535);
    r.bz = $urandom_range(0, 65535);
    return r;
  endfunction

  function automatic ring_t fill_ring(logic signed [31:0] c, logic signed [15:0] a,
                                      logic signed [15:0] b);
    ring_t r;
    r.cx = c; r.cy = c; r.cz = c;
    r.ax = a; r.ay = a; r.az = a;
    r.bx = b; r.by = b; r.bz = b;
    return r;
  endfunction

  // wait until every expected vertex has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS:       m_radius = data[30:0];
      REG_SLICES:       m_slices = data[5:0];
      REG_ANGLE_STEP:   m_step   = data;
      REG_CIRCLE_TOTAL: m_total  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] rad, input logic [31:0] sl,
                            input logic [31:0] st, input logic [31:0] tot);
    wait_drained();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_SLICES, sl);
    write_reg(REG_ANGLE_STEP, st);
    write_reg(REG_CIRCLE_TOTAL, tot);
  endtask

  task automatic test_reset_values();
    send_ring(fill_ring(32'sd0, 16'sd0, 16'sd0));
    send_ring(fill_ring(32'sd65536, 16'sd32767, -16'sd32768));
  endtask

  task automatic test_directed_cases();
    // saturation of position at both rails, widest radius and a step of two pi
    set_config(32'hFFFF_FFFF, 3, TWO_PI_Q29, 5);
    send_ring(fill_ring(32'sh7FFF_FFFF, 16'sd32767, 16'sd32767));
    send_ring(fill_ring(-32'sh8000_0000, -16'sd32768, -16'sd32768));
    // zero radius gives a zero offset and zero normal
    set_config(0, 2, 32'h8000_0000, 5);
    send_ring(random_ring());
    // zero slice count, step past two pi
    set_config(65536, 0, 32'hFFFF_FFFF, 5);
    send_ring(random_ring());
    // zero axes
    send_ring(fill_ring(32'sd12345, 16'sd0, 16'sd0));
    // largest slice count
    set_config(32'h0040_0000, 63, 53544435, 5);
    send_ring(random_ring());
    // total lowered to two, so the ring counter wraps back to zero
    set_config(32'h0002_0000, 4, 32'h0A00_0000, 2);
    send_ring(random_ring());
    send_ring(random_ring());
    // zero total and widest total
    set_config(32'h0002_0000, 4, 0, 0);
    send_ring(random_ring());
    set_config(32'h0002_0000, 4, 32'h2000_0000, 65535);
    send_ring(random_ring());
    send_ring(random_ring());
  endtask

  task automatic test_random_phases();
    int n;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (p == 5) begin
        set_config($urandom, 63, $urandom, $urandom_range(1, 6));
        n = 4;
      end else begin
        set_config((p % 2) ? $urandom : $urandom_range(0, 32'h0010_0000),
                   $urandom_range(0, 7) | ($urandom_range(0, 3) << 6),
                   $urandom, (p < 4) ? $urandom_range(1, 9) : $urandom_range(0, 65535));
        n = 48;
      end
      for (int k = 0; k < n; k++) send_ring(random_ring());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(32'h0003_0000, 2, $urandom, 7);
    hold_req = hold_req + 1;
    for (int k = 0; k < 8; k++) send_ring(random_ring());
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 6;
    recv_stall_pct = 6;
    for (int k = 0; k < 3; k++) send_ring(random_ring());
    wait_drained();
    for (int k = 0; k < 3; k++) send_ring(random_ring());
  endtask

  initial begin
    clk = 0; rst_n = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0;
    in_centre_x = '0; in_centre_y = '0; in_centre_z = '0;
    in_first_axis_x = '0; in_first_axis_y = '0; in_first_axis_z = '0;
    in_second_axis_x = '0; in_second_axis_y = '0; in_second_axis_z = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 0;
    m_radius = RST_RADIUS; m_slices = RST_SLICES;
    m_step = RST_ANGLE_STEP; m_total = RST_CIRCLE_TOTAL; m_ring = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed_cases();
    test_random_phases();
    test_backpressure();
    test_drain_pause();

    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
